// ===== rtl/core/assg_pkg.sv =====
// ----------------------------------------------------------------------------
// assg_pkg: shared types and constants
// Widths, register indexes, sequencer states and the tracker decision record.
// ----------------------------------------------------------------------------
package assg_pkg;

	localparam int FADE_FRAC_BITS = 16;
	localparam int SCALE_W        = FADE_FRAC_BITS + 1;
	localparam int GAIN_W         = 24;
	localparam int MPL_W          = (SCALE_W > GAIN_W) ? SCALE_W : GAIN_W;
	localparam int MCAND_W        = 32;
	localparam int ACC_W          = MCAND_W + MPL_W;
	localparam int GAIN_SHIFT     = 16;
	localparam int LEN_W          = 36;
	localparam int POS_W          = 38;
	localparam int RATE_W         = 18;
	localparam int SEC_W          = 16;
	localparam int LVL_W          = 16;
	localparam int SKIP_W         = 8;
	localparam int OUT_W          = 16;
	localparam int CNT_W          = $clog2(MPL_W + 1);
	localparam int IDX_W          = 4;

	localparam logic [IDX_W-1:0] REG_SILENCE_LEVEL = 4'd0;
	localparam logic [IDX_W-1:0] REG_SAMPLE_RATE   = 4'd1;
	localparam logic [IDX_W-1:0] REG_SKIP_SECONDS  = 4'd2;
	localparam logic [IDX_W-1:0] REG_SONG_LENGTH   = 4'd3;
	localparam logic [IDX_W-1:0] REG_FADE_LENGTH   = 4'd4;
	localparam logic [IDX_W-1:0] REG_PLAY_FOREVER  = 4'd5;
	localparam logic [IDX_W-1:0] REG_GAIN          = 4'd6;
	localparam logic [IDX_W-1:0] REG_WIDE_INPUT    = 4'd7;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_GAIN,
		ST_CLAMP,
		ST_FADE
	} state_t;

	typedef enum logic [0:0] {
		ST_FADE_RUN,
		ST_FADE_DONE
	} fade_phase_t;

	typedef struct packed {
		logic               keep;
		logic               fade_en;
		logic               last;
		logic [SEC_W-1:0]   secs;
		logic [LEN_W:0]     remain;
	} track_t;

endpackage

// ===== rtl/core/assg_smul.sv =====
// ----------------------------------------------------------------------------
// assg_smul: bit-serial unsigned multiplier
// Consumes one multiplier bit per step, shift-and-add into an accumulator.
// ----------------------------------------------------------------------------
module assg_smul import assg_pkg::*; (
	input  logic               clk,
	input  logic               load,
	input  logic               step,
	input  logic [MCAND_W-1:0] mcand,
	input  logic [MPL_W-1:0]   mplier,
	output logic [ACC_W-1:0]   product
);

	logic [ACC_W-1:0] a_q;
	logic [MPL_W-1:0] b_q;
	logic [ACC_W-1:0] acc_q;

	always_ff @(posedge clk) begin
		if (load) begin
			a_q   <= {{(ACC_W-MCAND_W){1'b0}}, mcand};
			b_q   <= mplier;
			acc_q <= '0;
		end else if (step) begin
			if (b_q[0]) begin
				acc_q <= acc_q + a_q;
			end
			a_q <= {a_q[ACC_W-2:0], 1'b0};
			b_q <= {1'b0, b_q[MPL_W-1:1]};
		end
	end

	assign product = acc_q;

endmodule

// ===== rtl/core/assg_sdiv.sv =====
// ----------------------------------------------------------------------------
// assg_sdiv: restoring divider for the fade scale
// One quotient bit per step; the numerator does not exceed the divisor for pairs inside the fade.
// ----------------------------------------------------------------------------
module assg_sdiv import assg_pkg::*; (
	input  logic               clk,
	input  logic               load,
	input  logic               step,
	input  logic [LEN_W:0]     num,
	input  logic [LEN_W-1:0]   den,
	output logic [SCALE_W-1:0] quo
);

	logic [LEN_W+1:0]   rem_q;
	logic [LEN_W-1:0]   den_q;
	logic [SCALE_W-1:0] quo_q;
	logic [LEN_W+1:0]   den_ext;
	logic               ge;
	logic [LEN_W+1:0]   rem_sub;

	assign den_ext = {2'b00, den_q};
	assign ge      = rem_q >= den_ext;
	assign rem_sub = ge ? (rem_q - den_ext) : rem_q;

	always_ff @(posedge clk) begin
		if (load) begin
			rem_q <= {1'b0, num};
			den_q <= den;
			quo_q <= '0;
		end else if (step) begin
			rem_q <= {rem_sub[LEN_W:0], 1'b0};
			quo_q <= {quo_q[SCALE_W-2:0], ge};
		end
	end

	assign quo = quo_q;

endmodule

// ===== rtl/core/assg_track.sv =====
// ----------------------------------------------------------------------------
// assg_track: silence tracker and play position
// Decides per request whether the pair is kept, faded or marked last.
// ----------------------------------------------------------------------------
module assg_track import assg_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [31:0]       left_sample,
	input  logic [31:0]       right_sample,
	input  logic [LVL_W-1:0]  silence_level,
	input  logic [RATE_W-1:0] samples_per_second,
	input  logic [SKIP_W-1:0] skip_start_seconds,
	input  logic [LEN_W-1:0]  song_length_samples,
	input  logic [LEN_W-1:0]  fade_length_samples,
	input  logic              play_forever,
	input  logic              wide_input,
	output logic [31:0]       left_val,
	output logic [31:0]       right_val,
	output track_t            info
);

	logic [31:0]       prev_left_q;
	logic [31:0]       prev_right_q;
	logic [RATE_W-1:0] cnt_q;
	logic [SEC_W-1:0]  sec_q;
	logic              skip_q;
	logic [POS_W-1:0]  pos_q;

	logic [RATE_W-1:0] cnt_n;
	logic [SEC_W-1:0]  sec_n;
	logic              skip_n;
	logic [31:0]       dl;
	logic [31:0]       dr;
	logic [31:0]       lim;
	logic              quiet;
	logic [RATE_W-1:0] rate;
	logic [RATE_W:0]   cnt_inc;
	logic [SEC_W-1:0]  sec_t;
	logic              skip_eff;
	logic [POS_W-1:0]  total;
	logic              ended;

	assign left_val  = wide_input ? left_sample  : {{16{left_sample[15]}},  left_sample[15:0]};
	assign right_val = wide_input ? right_sample : {{16{right_sample[15]}}, right_sample[15:0]};

	assign dl    = left_val  - prev_left_q  + {16'b0, silence_level};
	assign dr    = right_val - prev_right_q + {16'b0, silence_level};
	assign lim   = {15'b0, silence_level, 1'b0};
	assign quiet = (dl <= lim) && (dr <= lim);

	assign rate     = (samples_per_second == '0) ? RATE_W'(1) : samples_per_second;
	assign cnt_inc  = {1'b0, cnt_q} + (RATE_W+1)'(1);
	assign sec_t    = (sec_q == '1) ? sec_q : sec_q + SEC_W'(1);
	assign skip_eff = skip_q && (skip_start_seconds != '0);

	always_comb begin
		cnt_n  = '0;
		sec_n  = '0;
		skip_n = 1'b0;
		if (quiet) begin
			skip_n = skip_eff;
			sec_n  = sec_q;
			cnt_n  = cnt_inc[RATE_W-1:0];
			if (cnt_inc >= {1'b0, rate}) begin
				cnt_n = RATE_W'(cnt_inc - {1'b0, rate});
				sec_n = sec_t;
				if (skip_eff && (sec_t >= {8'b0, skip_start_seconds})) begin
					skip_n = 1'b0;
					sec_n  = '0;
				end
			end
		end
	end

	assign total = {1'b0, {1'b0, song_length_samples} + {1'b0, fade_length_samples}};
	assign ended = !play_forever && (pos_q >= total);

	assign info.keep    = !(quiet && skip_n) && !ended;
	assign info.fade_en = !play_forever && (fade_length_samples != '0) &&
		(pos_q >= {2'b0, song_length_samples}) && (pos_q < total);
	assign info.last    = !play_forever && ({1'b0, pos_q} + (POS_W+1)'(1) >= {1'b0, total});
	assign info.secs    = sec_n;
	assign info.remain  = LEN_W'(0) + (total[LEN_W:0] - pos_q[LEN_W:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_left_q  <= '0;
			prev_right_q <= '0;
			cnt_q        <= '0;
			sec_q        <= '0;
			skip_q       <= 1'b1;
			pos_q        <= '0;
		end else if (accept) begin
			prev_left_q  <= left_val;
			prev_right_q <= right_val;
			cnt_q        <= cnt_n;
			sec_q        <= sec_n;
			skip_q       <= skip_n;
			if (info.keep && (pos_q != '1)) begin
				pos_q <= pos_q + POS_W'(1);
			end
		end
	end

endmodule

// ===== rtl/core/audio_silence_skip_gain_fade.sv =====
// ----------------------------------------------------------------------------
// audio_silence_skip_gain_fade: silence skip, gain and fade-out for stereo
// Top level: config registers, sequencer, serial arithmetic lanes, output.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid / in_stall) takes one stereo pair per request.
//    The block raises in_stall while a pair is being worked on.
//  - Output channel (out_valid / out_stall) delivers at most one result per
//    input pair; dropped pairs (leading silence, song ended) give none.
//  - Config writes (cfg_valid / cfg_ready, cfg_index, cfg_data) are always
//    taken; write them only while the block is idle.
//  - Sequence: a kept pair runs the serial gain multiply, which also runs the
//    17-step fade divider, then the clamp state. Without a fade the clamp
//    state loads the output register once the output slot is free, and the
//    next pair is taken after that. With the fade active, the serial fade
//    multiply and an output load step follow, the load again waiting for a
//    free output slot. A dropped pair leaves the block idle and ready for
//    the next pair.
//  - The output register holds a finished result while the receiver
//    stalls; the next pair is taken meanwhile and waits at its last step.
//  - Reset clears silence tracking, position and config to defaults, and
//    arms the start skip.
// ----------------------------------------------------------------------------
module audio_silence_skip_gain_fade import assg_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic signed [31:0]      left_sample,
	input  logic signed [31:0]      right_sample,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic signed [OUT_W-1:0] left_out,
	output logic signed [OUT_W-1:0] right_out,
	output logic                    last_sample,
	output logic [SEC_W-1:0]        silence_seconds,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [IDX_W-1:0]        cfg_index,
	input  logic [LEN_W-1:0]        cfg_data
);

	// configuration registers
	logic [LVL_W-1:0]  silence_level_q;
	logic [RATE_W-1:0] sample_rate_q;
	logic [SKIP_W-1:0] skip_seconds_q;
	logic [LEN_W-1:0]  song_length_q;
	logic [LEN_W-1:0]  fade_length_q;
	logic              play_forever_q;
	logic [GAIN_W-1:0] gain_q;
	logic              wide_input_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			silence_level_q <= LVL_W'(8);
			sample_rate_q   <= RATE_W'(44100);
			skip_seconds_q  <= SKIP_W'(5);
			song_length_q   <= '0;
			fade_length_q   <= '0;
			play_forever_q  <= 1'b1;
			gain_q          <= GAIN_W'(65536);
			wide_input_q    <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_SILENCE_LEVEL: silence_level_q <= cfg_data[LVL_W-1:0];
				REG_SAMPLE_RATE:   sample_rate_q   <= cfg_data[RATE_W-1:0];
				REG_SKIP_SECONDS:  skip_seconds_q  <= cfg_data[SKIP_W-1:0];
				REG_SONG_LENGTH:   song_length_q   <= cfg_data;
				REG_FADE_LENGTH:   fade_length_q   <= cfg_data;
				REG_PLAY_FOREVER:  play_forever_q  <= cfg_data[0];
				REG_GAIN:          gain_q          <= cfg_data[GAIN_W-1:0];
				REG_WIDE_INPUT:    wide_input_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// sequencer signals
	state_t            state_q;
	state_t            state_n;
	fade_phase_t       phase;
	logic [CNT_W-1:0]  cnt_q;
	logic              accept;
	logic              mul_load;
	logic              mul_step;
	logic              div_step;
	logic              out_load;
	logic              slot_free;

	logic [31:0]       left_val;
	logic [31:0]       right_val;
	track_t            info;

	// per-pair working registers
	logic              l_neg_q;
	logic              r_neg_q;
	logic              fade_q;
	logic              last_q;
	logic [SEC_W-1:0]  secs_q;
	logic [OUT_W-1:0]  l_clamp;
	logic [OUT_W-1:0]  r_clamp;

	logic [MCAND_W-1:0] l_mcand;
	logic [MCAND_W-1:0] r_mcand;
	logic [MPL_W-1:0]   mplier;
	logic [ACC_W-1:0]   l_prod;
	logic [ACC_W-1:0]   r_prod;
	logic [SCALE_W-1:0] scale;

	assign accept    = in_valid && !in_stall;
	assign slot_free = !out_valid || !out_stall;

	assg_track u_track (
		.clk                (clk),
		.arst_n             (arst_n),
		.accept             (accept),
		.left_sample        (left_sample),
		.right_sample       (right_sample),
		.silence_level      (silence_level_q),
		.samples_per_second (sample_rate_q),
		.skip_start_seconds (skip_seconds_q),
		.song_length_samples(song_length_q),
		.fade_length_samples(fade_length_q),
		.play_forever       (play_forever_q),
		.wide_input         (wide_input_q),
		.left_val           (left_val),
		.right_val          (right_val),
		.info               (info)
	);

	// Gain pass takes the sample magnitude; the fade pass takes the clamped one.
	always_comb begin
		if (state_q == ST_IDLE) begin
			l_mcand = left_val[31]  ? (32'd0 - left_val)  : left_val;
			r_mcand = right_val[31] ? (32'd0 - right_val) : right_val;
			mplier  = MPL_W'(gain_q);
		end else begin
			l_mcand = {16'b0, l_clamp};
			r_mcand = {16'b0, r_clamp};
			mplier  = MPL_W'(scale);
		end
	end

	assg_smul u_mul_l (
		.clk    (clk),
		.load   (mul_load),
		.step   (mul_step),
		.mcand  (l_mcand),
		.mplier (mplier),
		.product(l_prod)
	);

	assg_smul u_mul_r (
		.clk    (clk),
		.load   (mul_load),
		.step   (mul_step),
		.mcand  (r_mcand),
		.mplier (mplier),
		.product(r_prod)
	);

	assg_sdiv u_div (
		.clk (clk),
		.load(accept),
		.step(div_step),
		.num (info.remain),
		.den (fade_length_q),
		.quo (scale)
	);

	// fade step count reached: results are in the accumulators
	assign phase = (cnt_q == CNT_W'(SCALE_W)) ? ST_FADE_DONE : ST_FADE_RUN;

	// next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && info.keep) state_n = ST_GAIN;
			end
			ST_GAIN: begin
				if (cnt_q == CNT_W'(MPL_W - 1)) state_n = ST_CLAMP;
			end
			ST_CLAMP: begin
				if (fade_q) state_n = ST_FADE;
				else if (slot_free) state_n = ST_IDLE;
			end
			ST_FADE: begin
				if (phase == ST_FADE_DONE && slot_free) state_n = ST_IDLE;
			end
			default: state_n = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_stall = 1'b1;
		mul_load = 1'b0;
		mul_step = 1'b0;
		div_step = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				mul_load = accept;
			end
			ST_GAIN: begin
				mul_step = 1'b1;
				div_step = cnt_q < CNT_W'(SCALE_W);
			end
			ST_CLAMP: begin
				mul_load = fade_q;
				out_load = !fade_q && slot_free;
			end
			ST_FADE: begin
				mul_step = phase == ST_FADE_RUN;
				out_load = phase == ST_FADE_DONE && slot_free;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_n;
			if (mul_load || state_q == ST_IDLE) cnt_q <= '0;
			else if (mul_step) cnt_q <= cnt_q + CNT_W'(1);
			else if (state_q == ST_GAIN || state_q == ST_CLAMP) cnt_q <= '0;
		end
	end

	// clamp of the gained magnitude: truncate toward zero, then saturate
	localparam int Q_W = ACC_W - GAIN_SHIFT;
	logic [Q_W-1:0] l_q;
	logic [Q_W-1:0] r_q;

	assign l_q = l_prod[ACC_W-1:GAIN_SHIFT];
	assign r_q = r_prod[ACC_W-1:GAIN_SHIFT];

	always_comb begin
		if (l_q > (l_neg_q ? Q_W'(32768) : Q_W'(32767)))
			l_clamp = l_neg_q ? OUT_W'(32768) : OUT_W'(32767);
		else
			l_clamp = l_q[OUT_W-1:0];
		if (r_q > (r_neg_q ? Q_W'(32768) : Q_W'(32767)))
			r_clamp = r_neg_q ? OUT_W'(32768) : OUT_W'(32767);
		else
			r_clamp = r_q[OUT_W-1:0];
	end

	// fade: floor of signed product, so round the magnitude up when negative
	localparam logic [ACC_W-1:0] FRAC_ROUND = ACC_W'((64'd1 << FADE_FRAC_BITS) - 64'd1);
	logic [ACC_W-1:0] l_up;
	logic [ACC_W-1:0] r_up;
	logic [OUT_W-1:0] l_mag_out;
	logic [OUT_W-1:0] r_mag_out;
	logic [OUT_W-1:0] l_fin;
	logic [OUT_W-1:0] r_fin;

	assign l_up = (l_neg_q ? l_prod + FRAC_ROUND : l_prod) >> FADE_FRAC_BITS;
	assign r_up = (r_neg_q ? r_prod + FRAC_ROUND : r_prod) >> FADE_FRAC_BITS;
	assign l_mag_out = (state_q == ST_FADE) ? l_up[OUT_W-1:0] : l_clamp;
	assign r_mag_out = (state_q == ST_FADE) ? r_up[OUT_W-1:0] : r_clamp;
	assign l_fin = l_neg_q ? (OUT_W'(0) - l_mag_out) : l_mag_out;
	assign r_fin = r_neg_q ? (OUT_W'(0) - r_mag_out) : r_mag_out;

	always_ff @(posedge clk) begin
		if (accept) begin
			l_neg_q <= left_val[31];
			r_neg_q <= right_val[31];
			fade_q  <= info.fade_en;
			last_q  <= info.last;
			secs_q  <= info.secs;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_load) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			left_out        <= l_fin;
			right_out       <= r_fin;
			last_sample     <= last_q;
			silence_seconds <= secs_q;
		end
	end

	// a kept pair starts the gain pass on the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && info.keep) |=> (state_q == ST_GAIN && cnt_q == '0))
		else $error("gain pass did not start after a kept pair");

	// a dropped pair leaves the block ready
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !info.keep) |=> (state_q == ST_IDLE))
		else $error("dropped pair left the sequencer busy");

	// a result load always produces a valid output next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> out_valid)
		else $error("result load lost");

	// no result may overwrite one still held for a stalled receiver
	assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> !(out_valid && out_stall))
		else $error("held result overwritten");

endmodule
